### rtl/psf_pkg.sv
// shared constants, command codes and the queued operation type
package psf_pkg;

  // default geometry
  localparam int DEF_SCREEN_WIDTH  = 480;
  localparam int DEF_SCREEN_HEIGHT = 272;
  localparam int DEF_POINT_SIZE    = 16;
  localparam int DEF_QUEUE_DEPTH   = 2;

  // upper bounds of the geometry, they size the queued fields
  localparam int MAX_POINT_SIZE    = 64;
  localparam int MAX_SCREEN_HEIGHT = 1024;
  localparam int MAX_ROW_BYTES     = 256;

  localparam int ROWS_W  = $clog2(MAX_POINT_SIZE);
  localparam int BYTES_W = $clog2((MAX_POINT_SIZE + 2) / 4 + 1);
  localparam int OFS_W   = $clog2(MAX_SCREEN_HEIGHT * MAX_ROW_BYTES);
  localparam int COLOR_W = 2;

  // configuration reset values
  localparam logic [COLOR_W-1:0] FG_COLOR_RST   = 2'd1;
  localparam logic [COLOR_W-1:0] FILL_COLOR_RST = 2'd0;

  typedef enum logic [1:0] {
    CMD_DRAW = 2'd0,
    CMD_FILL = 2'd1,
    CMD_SWAP = 2'd2,
    CMD_READ = 2'd3
  } psf_cmd_e;

  typedef enum logic {
    CFG_FG = 1'b0,
    CFG_BG = 1'b1
  } psf_cfg_e;

  // one classified command, as handed from front to back
  typedef struct packed {
    psf_cmd_e            cmd;
    logic                buf_sel;     // buffer of a read
    logic                active;      // draw not fully clipped, read in range
    logic [OFS_W-1:0]    offset;      // row * row_bytes + byte within a buffer
    logic [ROWS_W-1:0]   rows_m1;     // drawn rows minus one
    logic [BYTES_W-1:0]  bytes_m1;    // drawn bytes per row minus one
    logic [3:0]          first_mask;  // pixels covered in the leftmost byte
    logic [3:0]          last_mask;   // pixels covered in the rightmost byte
  } psf_op_t;

endpackage

### rtl/psf_if.sv
// valid/ready channel interfaces for commands and results
interface psf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [8:0] x_position;
  logic [8:0] y_position;
  logic       buffer_select;
  logic [8:0] read_row;
  logic [6:0] byte_column;

  modport source (
    output valid, command, x_position, y_position, buffer_select, read_row, byte_column,
    input  ready
  );
  modport sink (
    input  valid, command, x_position, y_position, buffer_select, read_row, byte_column,
    output ready
  );
endinterface

interface psf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       inactive_buffer;

  modport source (output valid, read_data, inactive_buffer, input ready);
  modport sink   (input valid, read_data, inactive_buffer, output ready);
endinterface

### rtl/psf_front.sv
// command front end: accepts commands and works out clipping, masks and offsets
module psf_front #(
  parameter int SCREEN_WIDTH  = psf_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = psf_pkg::DEF_SCREEN_HEIGHT,
  parameter int POINT_SIZE    = psf_pkg::DEF_POINT_SIZE
) (
  psf_in_if.sink           cmd_i,
  input  logic             queue_ready_i,
  input  logic             clear_active_i,
  output psf_pkg::psf_op_t op_o,
  output logic             op_valid_o
);

  localparam int RowBytes = SCREEN_WIDTH / 4;
  localparam int PixCols  = RowBytes * 4;
  localparam int Span     = POINT_SIZE - 1;

  logic [9:0] x_end, x_last, y_end, y_last;
  logic [8:0] row_sel;
  logic [6:0] col_sel;
  logic       is_read, draw_on, read_on;

  // no transaction while the clearing pass runs or the queue is full
  assign cmd_i.ready = queue_ready_i && !clear_active_i;
  assign op_valid_o  = cmd_i.valid && cmd_i.ready;

  // square extent clipped to the screen
  always_comb begin
    x_end  = {1'b0, cmd_i.x_position} + 10'(Span);
    y_end  = {1'b0, cmd_i.y_position} + 10'(Span);
    x_last = (x_end > 10'(PixCols - 1)) ? 10'(PixCols - 1) : x_end;
    y_last = (y_end > 10'(SCREEN_HEIGHT - 1)) ? 10'(SCREEN_HEIGHT - 1) : y_end;
    draw_on = (cmd_i.x_position < PixCols) && (cmd_i.y_position < SCREEN_HEIGHT);
    read_on = (cmd_i.read_row < SCREEN_HEIGHT) && (cmd_i.byte_column < RowBytes);
  end

  // classified operation with its byte offset inside a buffer
  always_comb begin
    is_read = (psf_pkg::psf_cmd_e'(cmd_i.command) == psf_pkg::CMD_READ);
    row_sel = is_read ? cmd_i.read_row : cmd_i.y_position;
    col_sel = is_read ? cmd_i.byte_column : cmd_i.x_position[8:2];

    op_o.cmd        = psf_pkg::psf_cmd_e'(cmd_i.command);
    op_o.buf_sel    = cmd_i.buffer_select;
    op_o.active     = is_read ? read_on : draw_on;
    op_o.offset     = psf_pkg::OFS_W'(row_sel) * psf_pkg::OFS_W'(RowBytes)
                    + psf_pkg::OFS_W'(col_sel);
    op_o.rows_m1    = psf_pkg::ROWS_W'(y_last - {1'b0, cmd_i.y_position});
    op_o.bytes_m1   = psf_pkg::BYTES_W'(x_last[9:2] - {1'b0, cmd_i.x_position[8:2]});
    op_o.first_mask = 4'b1111 << cmd_i.x_position[1:0];
    op_o.last_mask  = 4'b1111 >> (2'd3 - x_last[1:0]);
  end

endmodule

### rtl/psf_queue.sv
// small queue of classified operations between front and back
module psf_queue #(
  parameter int DEPTH = psf_pkg::DEF_QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  psf_pkg::psf_op_t push_data_i,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  output psf_pkg::psf_op_t pop_data_o,
  output logic             pop_valid_o,
  input  logic             pop_ready_i
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  psf_pkg::psf_op_t entry_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/psf_back.sv
// execution back end: frame memory, draw/fill/swap/read sequencer, result register
module psf_back #(
  parameter int SCREEN_WIDTH  = psf_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = psf_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  psf_pkg::psf_op_t              op_i,
  input  logic                          op_valid_i,
  output logic                          op_ready_o,
  input  logic [psf_pkg::COLOR_W-1:0]   fg_color_i,
  input  logic [psf_pkg::COLOR_W-1:0]   fill_color_i,
  output logic                          clear_active_o,
  psf_out_if.source                     res_o
);

  localparam int RowBytes   = SCREEN_WIDTH / 4;
  localparam int FrameBytes = SCREEN_HEIGHT * RowBytes;
  localparam int TotalBytes = 2 * FrameBytes;
  localparam int AddrW      = $clog2(TotalBytes);

  typedef enum logic [6:0] {
    ST_CLEAR   = 7'b0000001,
    ST_IDLE    = 7'b0000010,
    ST_DRAW_RD = 7'b0000100,
    ST_DRAW_WR = 7'b0001000,
    ST_FILL    = 7'b0010000,
    ST_READ    = 7'b0100000,
    ST_DONE    = 7'b1000000
  } state_e;

  // spread a four-pixel mask to the eight bits of a byte
  function automatic logic [7:0] expand_mask(input logic [3:0] m);
    logic [7:0] b;
    for (int k = 0; k < 4; k++) begin
      b[2*k +: 2] = {2{m[k]}};
    end
    return b;
  endfunction

  state_e                       state_q, state_d;
  logic                         draw_buf_q, draw_buf_d;
  logic [AddrW-1:0]             sweep_addr_q, sweep_addr_d, sweep_last_q, sweep_last_d;
  psf_pkg::psf_op_t             cur_op_q, cur_op_d;
  logic [AddrW-1:0]             row_addr_q, row_addr_d;
  logic [psf_pkg::BYTES_W-1:0]  byte_idx_q, byte_idx_d;
  logic [psf_pkg::ROWS_W-1:0]   row_idx_q, row_idx_d;
  logic [7:0]                   res_data_q, res_data_d;
  logic                         out_valid_q, out_valid_d;
  logic [7:0]                   out_data_q;
  logic                         out_buf_q;

  logic [7:0]                   mem [TotalBytes];
  logic [7:0]                   rdata_q;
  logic                         mem_we;
  logic [AddrW-1:0]             mem_waddr, mem_raddr;
  logic [7:0]                   mem_wdata;

  logic [AddrW-1:0]             cur_addr, op_addr, fill_base;
  logic [3:0]                   pix_mask;
  logic [7:0]                   bit_mask, fg_byte;
  logic                         op_pop, byte_step, out_load;

  assign clear_active_o = (state_q == ST_CLEAR);
  assign op_ready_o     = (state_q == ST_IDLE);
  assign op_pop         = op_valid_i && op_ready_o;
  assign out_load       = (state_q == ST_DONE) && (!out_valid_q || res_o.ready);

  // addresses and masks
  always_comb begin
    cur_addr  = row_addr_q + AddrW'(byte_idx_q);
    op_addr   = (((op_i.cmd == psf_pkg::CMD_READ) ? op_i.buf_sel : draw_buf_q)
                 ? AddrW'(FrameBytes) : '0) + AddrW'(op_i.offset);
    fill_base = draw_buf_q ? AddrW'(FrameBytes) : '0;
    pix_mask  = ((byte_idx_q == '0) ? cur_op_q.first_mask : 4'hF)
              & ((byte_idx_q == cur_op_q.bytes_m1) ? cur_op_q.last_mask : 4'hF);
    bit_mask  = expand_mask(pix_mask);
    fg_byte   = {4{fg_color_i}};
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    draw_buf_d   = draw_buf_q;
    sweep_addr_d = sweep_addr_q;
    sweep_last_d = sweep_last_q;
    cur_op_d     = cur_op_q;
    row_addr_d   = row_addr_q;
    byte_idx_d   = byte_idx_q;
    row_idx_d    = row_idx_q;
    res_data_d   = res_data_q;
    mem_we       = 1'b0;
    mem_waddr    = cur_addr;
    mem_wdata    = fg_byte;
    mem_raddr    = (state_q == ST_IDLE) ? op_addr : cur_addr;
    byte_step    = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_addr_q;
        mem_wdata = '0;
        if (sweep_addr_q == sweep_last_q) begin
          state_d = ST_IDLE;
        end else begin
          sweep_addr_d = sweep_addr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (op_pop) begin
          cur_op_d   = op_i;
          res_data_d = '0;
          row_addr_d = op_addr;
          byte_idx_d = '0;
          row_idx_d  = '0;
          case (op_i.cmd)
            psf_pkg::CMD_DRAW: state_d = op_i.active ? ST_DRAW_RD : ST_DONE;
            psf_pkg::CMD_FILL: begin
              sweep_addr_d = fill_base;
              sweep_last_d = fill_base + AddrW'(FrameBytes - 1);
              state_d      = ST_FILL;
            end
            psf_pkg::CMD_SWAP: begin
              draw_buf_d = !draw_buf_q;
              state_d    = ST_DONE;
            end
            psf_pkg::CMD_READ: state_d = op_i.active ? ST_READ : ST_DONE;
            default:           state_d = ST_DONE;
          endcase
        end
      end
      ST_DRAW_RD: begin
        // whole bytes are written at once, edge bytes wait for the read
        if (pix_mask == 4'hF) begin
          mem_we    = 1'b1;
          byte_step = 1'b1;
        end else begin
          state_d = ST_DRAW_WR;
        end
      end
      ST_DRAW_WR: begin
        mem_we    = 1'b1;
        mem_wdata = (rdata_q & ~bit_mask) | (fg_byte & bit_mask);
        byte_step = 1'b1;
        state_d   = ST_DRAW_RD;
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_addr_q;
        mem_wdata = {4{fill_color_i}};
        if (sweep_addr_q == sweep_last_q) begin
          state_d = ST_DONE;
        end else begin
          sweep_addr_d = sweep_addr_q + 1'b1;
        end
      end
      ST_READ: begin
        res_data_d = rdata_q;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // walk bytes of a row, then rows of the square
    if (byte_step) begin
      if (byte_idx_q == cur_op_q.bytes_m1) begin
        byte_idx_d = '0;
        if (row_idx_q == cur_op_q.rows_m1) begin
          state_d = ST_DONE;
        end else begin
          row_idx_d  = row_idx_q + 1'b1;
          row_addr_d = row_addr_q + AddrW'(RowBytes);
          state_d    = ST_DRAW_RD;
        end
      end else begin
        byte_idx_d = byte_idx_q + 1'b1;
        state_d    = ST_DRAW_RD;
      end
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.read_data       = out_data_q;
  assign res_o.inactive_buffer = out_buf_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      draw_buf_q   <= 1'b1;
      sweep_addr_q <= '0;
      sweep_last_q <= AddrW'(TotalBytes - 1);
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      draw_buf_q   <= draw_buf_d;
      sweep_addr_q <= sweep_addr_d;
      sweep_last_q <= sweep_last_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_op_q   <= cur_op_d;
    row_addr_q <= row_addr_d;
    byte_idx_q <= byte_idx_d;
    row_idx_q  <= row_idx_d;
    res_data_q <= res_data_d;
    if (out_load) begin
      out_data_q <= res_data_q;
      out_buf_q  <= draw_buf_q;
    end
  end

  // frame memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  // no operation leaves the queue during the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !op_pop)
    else $error("operation taken during clearing pass");

  // every memory write stays inside the two buffers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (mem_waddr < TotalBytes))
    else $error("frame memory write out of range");

  // a swap flips the draw buffer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_pop && (op_i.cmd == psf_pkg::CMD_SWAP)) |=> (draw_buf_q != $past(draw_buf_q)))
    else $error("swap did not toggle draw buffer");

  // a result only appears after the done state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result presented without a finished command");

endmodule

### rtl/packed_2bpp_square_fill_top.sv
// top level of the double-buffered 2bpp frame store with square draw and fill
//
// Commands enter on cmd_i (valid/ready), one result per command leaves on res_o.
// A transaction on cmd_i is classified at once and queued; the back end then
// runs it against a single frame memory with one write and one read port.
// From queue head to result register: a swap flips the draw buffer, a read in
// range fetches one byte, a fill writes every byte of the draw buffer, and a
// draw writes each fully covered byte directly and reads each partly covered
// edge byte before writing it back, over every unclipped row of the square.
// The memory write port bounds the rate: it writes at most one byte per cycle.
// Configuration writes on cfg_we_i/cfg_idx_i/cfg_data_i take effect at once
// and belong in idle periods.
// After reset the block zeroes all 2*SCREEN_HEIGHT*(SCREEN_WIDTH/4) bytes of both
// buffers (65280 at the defaults) with cmd_i.ready low; colors reset to
// foreground 1, background 0, and buffer 1 is the one drawn into.
// When res_o stalls, the finished result waits in the output register; the
// queue keeps taking commands until it is full, then cmd_i.ready drops.
module packed_2bpp_square_fill_top #(
  parameter int SCREEN_WIDTH  = psf_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = psf_pkg::DEF_SCREEN_HEIGHT,
  parameter int POINT_SIZE    = psf_pkg::DEF_POINT_SIZE,
  parameter int QUEUE_DEPTH   = psf_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  psf_in_if.sink                      cmd_i,
  psf_out_if.source                   res_o,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [psf_pkg::COLOR_W-1:0] cfg_data_i
);

  logic [psf_pkg::COLOR_W-1:0] fg_color_q, fg_color_d, fill_color_q, fill_color_d;
  psf_pkg::psf_op_t            push_op, pop_op;
  logic                        push_valid, push_ready, pop_valid, pop_ready;
  logic                        clear_active;

  // configuration registers
  always_comb begin
    fg_color_d   = fg_color_q;
    fill_color_d = fill_color_q;
    if (cfg_we_i) begin
      case (psf_pkg::psf_cfg_e'(cfg_idx_i))
        psf_pkg::CFG_FG: fg_color_d   = cfg_data_i;
        psf_pkg::CFG_BG: fill_color_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_color_q   <= psf_pkg::FG_COLOR_RST;
      fill_color_q <= psf_pkg::FILL_COLOR_RST;
    end else begin
      fg_color_q   <= fg_color_d;
      fill_color_q <= fill_color_d;
    end
  end

  // command classification
  psf_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .POINT_SIZE    (POINT_SIZE)
  ) u_front (
    .cmd_i          (cmd_i),
    .queue_ready_i  (push_ready),
    .clear_active_i (clear_active),
    .op_o           (push_op),
    .op_valid_o     (push_valid)
  );

  // queue between front and back
  psf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (push_op),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .pop_data_o   (pop_op),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready)
  );

  // execution and frame memory
  psf_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (pop_op),
    .op_valid_i     (pop_valid),
    .op_ready_o     (pop_ready),
    .fg_color_i     (fg_color_q),
    .fill_color_i   (fill_color_q),
    .clear_active_o (clear_active),
    .res_o          (res_o)
  );

endmodule

### tb/tb_packed_2bpp_square_fill_top.sv
// self-checking testbench for the double-buffered 2bpp frame store with square draw and fill
module tb_packed_2bpp_square_fill_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCR_W       = psf_pkg::DEF_SCREEN_WIDTH;
  localparam int SCR_H       = psf_pkg::DEF_SCREEN_HEIGHT;
  localparam int PT_SIZE     = psf_pkg::DEF_POINT_SIZE;
  localparam int ROW_BYTES   = SCR_W / 4;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 205;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 200;
  localparam int CYCLE_LIMIT = 3_000_000;

  // one command transaction
  typedef struct {
    psf_pkg::psf_cmd_e op;
    logic [8:0]        x;
    logic [8:0]        y;
    logic              sel;
    logic [8:0]        row;
    logic [6:0]        col;
  } cmd_t;

  // one result transaction
  typedef struct {
    logic [7:0] data;
    logic       ibuf;
  } frame_result_t;

  // directed table row: a command, or a color write
  typedef struct {
    bit                is_cfg;
    psf_pkg::psf_cfg_e reg_idx;
    logic [1:0]        reg_val;
    cmd_t              cmd;
    bit                typed;
    frame_result_t     want;
  } step_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  psf_pkg::psf_cfg_e cfg_idx;
  logic [psf_pkg::COLOR_W-1:0] cfg_data;

  psf_in_if  cmd_if ();
  psf_out_if res_if ();

  packed_2bpp_square_fill_top DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cmd_i      (cmd_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // frame store mirror and its settings
  bit [7:0]     frame_model [2][SCR_H][ROW_BYTES];
  bit           draw_buf = 1'b1;
  bit [1:0]     fg_color = psf_pkg::FG_COLOR_RST;
  bit [1:0]     fill_color = psf_pkg::FILL_COLOR_RST;

  frame_result_t frame_results_q [$];
  step_t         directed_q [$];

  int  n_err;
  int  n_checked;
  int  n_draw, n_fill, n_swap, n_read, n_read_set, n_cfg;
  int  cycles;
  int  burst_left;
  int  aim_x, aim_y;
  bit  hold_req;
  frame_result_t got_want;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // apply one command to the mirror and return the result it should give
  function automatic frame_result_t apply_frame_cmd(input cmd_t c);
    frame_result_t r;
    int yy, xx, row, col;
    r.data = '0;
    yy = int'(c.y);
    xx = int'(c.x);
    case (c.op)
      psf_pkg::CMD_DRAW: begin
        n_draw++;
        for (row = yy; row < yy + PT_SIZE; row++)
          for (col = xx; col < xx + PT_SIZE; col++)
            if (row < SCR_H && col < ROW_BYTES * 4)
              frame_model[draw_buf][row][col / 4][(col % 4) * 2 +: 2] = fg_color;
      end
      psf_pkg::CMD_FILL: begin
        n_fill++;
        for (row = 0; row < SCR_H; row++)
          for (col = 0; col < ROW_BYTES; col++)
            frame_model[draw_buf][row][col] = {4{fill_color}};
      end
      psf_pkg::CMD_SWAP: begin
        n_swap++;
        draw_buf = ~draw_buf;
      end
      default: begin
        n_read++;
        if (int'(c.row) < SCR_H && int'(c.col) < ROW_BYTES)
          r.data = frame_model[c.sel][c.row][c.col];
        if (r.data != 0) n_read_set++;
      end
    endcase
    r.ibuf = draw_buf;
    return r;
  endfunction

  // table row builders
  function automatic step_t tx(input psf_pkg::psf_cmd_e op, input int x, input int y,
                               input bit sel, input int row, input int col,
                               input bit typed = 1'b0, input logic [7:0] data = '0,
                               input bit ibuf = 1'b0);
    step_t s;
    s.is_cfg    = 1'b0;
    s.reg_idx   = psf_pkg::CFG_FG;
    s.reg_val   = '0;
    s.cmd.op    = op;
    s.cmd.x     = x[8:0];
    s.cmd.y     = y[8:0];
    s.cmd.sel   = sel;
    s.cmd.row   = row[8:0];
    s.cmd.col   = col[6:0];
    s.typed     = typed;
    s.want.data = data;
    s.want.ibuf = ibuf;
    return s;
  endfunction

  function automatic step_t color_write(input psf_pkg::psf_cfg_e idx, input logic [1:0] val);
    step_t s;
    s = tx(psf_pkg::CMD_READ, 0, 0, 1'b0, 0, 0);
    s.is_cfg  = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  // offer one command and record its expected result once accepted
  task automatic send_cmd(input cmd_t c, input bit typed, input frame_result_t want);
    frame_result_t pred;
    cmd_if.valid         <= 1'b1;
    cmd_if.command       <= c.op;
    cmd_if.x_position    <= c.x;
    cmd_if.y_position    <= c.y;
    cmd_if.buffer_select <= c.sel;
    cmd_if.read_row      <= c.row;
    cmd_if.byte_column   <= c.col;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    pred = apply_frame_cmd(c);
    frame_results_q.push_back(typed ? want : pred);
  endtask

  // sender bursts with random gaps between them
  task automatic pace(input bit allow_gap);
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 32);
      if (allow_gap && $urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 24);
        cmd_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop offering and wait until every result is back
  task automatic settle();
    cmd_if.valid <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input psf_pkg::psf_cfg_e idx, input logic [1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == psf_pkg::CFG_FG) fg_color = val;
    else fill_color = val;
    n_cfg++;
    @(posedge clk);
  endtask

  // directed stimulus: reset contents, edges, clipping, every command
  task automatic build_directed();
    directed_q.push_back(tx(psf_pkg::CMD_READ, 0, 0, 1'b0, 0, 0, 1'b1, 8'h00, 1'b1));
    directed_q.push_back(tx(psf_pkg::CMD_READ, 0, 0, 1'b1, 271, 119, 1'b1, 8'h00, 1'b1));
    // read beyond the screen
    directed_q.push_back(tx(psf_pkg::CMD_READ, 0, 0, 1'b1, 511, 127, 1'b1, 8'h00, 1'b1));
    directed_q.push_back(tx(psf_pkg::CMD_DRAW, 0, 0, 1'b0, 0, 0, 1'b1, 8'h00, 1'b1));
    directed_q.push_back(tx(psf_pkg::CMD_READ, 0, 0, 1'b1, 0, 0, 1'b1, 8'h55, 1'b1));
    directed_q.push_back(tx(psf_pkg::CMD_READ, 0, 0, 1'b1, 15, 3, 1'b1, 8'h55, 1'b1));
    directed_q.push_back(tx(psf_pkg::CMD_READ, 0, 0, 1'b1, 16, 0, 1'b1, 8'h00, 1'b1));
    // partial bytes on both sides
    directed_q.push_back(tx(psf_pkg::CMD_DRAW, 2, 100, 1'b0, 0, 0));
    directed_q.push_back(tx(psf_pkg::CMD_READ, 0, 0, 1'b1, 100, 0));
    directed_q.push_back(tx(psf_pkg::CMD_READ, 0, 0, 1'b1, 115, 4));
    // square past the right and bottom edges
    directed_q.push_back(tx(psf_pkg::CMD_DRAW, 470, 265, 1'b0, 0, 0));
    directed_q.push_back(tx(psf_pkg::CMD_READ, 0, 0, 1'b1, 271, 119));
    // square wholly off screen
    directed_q.push_back(tx(psf_pkg::CMD_DRAW, 511, 511, 1'b0, 0, 0, 1'b1, 8'h00, 1'b1));
    directed_q.push_back(color_write(psf_pkg::CFG_FG, 2'd3));
    directed_q.push_back(tx(psf_pkg::CMD_DRAW, 465, 0, 1'b0, 0, 0));
    directed_q.push_back(tx(psf_pkg::CMD_READ, 0, 0, 1'b1, 0, 116));
    directed_q.push_back(tx(psf_pkg::CMD_READ, 0, 0, 1'b1, 0, 119));
    directed_q.push_back(tx(psf_pkg::CMD_SWAP, 0, 0, 1'b0, 0, 0, 1'b1, 8'h00, 1'b0));
    directed_q.push_back(tx(psf_pkg::CMD_READ, 0, 0, 1'b0, 0, 0, 1'b1, 8'h00, 1'b0));
    directed_q.push_back(color_write(psf_pkg::CFG_BG, 2'd2));
    directed_q.push_back(tx(psf_pkg::CMD_FILL, 0, 0, 1'b0, 0, 0, 1'b1, 8'h00, 1'b0));
    directed_q.push_back(tx(psf_pkg::CMD_READ, 0, 0, 1'b0, 271, 119, 1'b1, 8'hAA, 1'b0));
    directed_q.push_back(tx(psf_pkg::CMD_READ, 0, 0, 1'b1, 0, 0));
    directed_q.push_back(tx(psf_pkg::CMD_SWAP, 0, 0, 1'b0, 0, 0, 1'b1, 8'h00, 1'b1));
    directed_q.push_back(color_write(psf_pkg::CFG_BG, 2'd3));
    directed_q.push_back(color_write(psf_pkg::CFG_FG, 2'd0));
    directed_q.push_back(tx(psf_pkg::CMD_FILL, 0, 0, 1'b0, 0, 0, 1'b1, 8'h00, 1'b1));
    directed_q.push_back(tx(psf_pkg::CMD_DRAW, 7, 3, 1'b0, 0, 0));
    directed_q.push_back(tx(psf_pkg::CMD_READ, 0, 0, 1'b1, 3, 1));
    directed_q.push_back(tx(psf_pkg::CMD_READ, 0, 0, 1'b1, 200, 50, 1'b1, 8'hFF, 1'b1));
  endtask

  // result receiver: stretches of full speed, random and heavy stalls, long hold-offs
  initial begin
    int hold_left;
    int stretch_left;
    int mode;
    bit rdy;
    hold_left    = 0;
    stretch_left = 0;
    mode         = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        if (stretch_left == 0) begin
          mode         = $urandom_range(0, 2);
          stretch_left = $urandom_range(16, 160);
        end
        stretch_left--;
        case (mode)
          0: rdy = 1'b1;
          1: rdy = $urandom_range(0, 1);
          default: rdy = ($urandom_range(0, 7) == 0);
        endcase
      end
      res_if.ready <= rdy;
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (res_if.valid && res_if.ready) begin
      if (frame_results_q.size() == 0) begin
        $error("result with nothing outstanding: read_data %0h inactive_buffer %0b",
               res_if.read_data, res_if.inactive_buffer);
        n_err++;
      end else begin
        got_want = frame_results_q.pop_front();
        if (res_if.read_data !== got_want.data) begin
          $error("result %0d read_data: expected %02h, actual %02h",
                 n_checked, got_want.data, res_if.read_data);
          n_err++;
        end
        if (res_if.inactive_buffer !== got_want.ibuf) begin
          $error("result %0d inactive_buffer: expected %0b, actual %0b",
                 n_checked, got_want.ibuf, res_if.inactive_buffer);
          n_err++;
        end
        n_checked++;
      end
    end
  end

  // watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $error("timeout with %0d results outstanding", frame_results_q.size());
    $display("== FAIL ==");
    $finish;
  end

  // main sequence
  initial begin
    cmd_t          c;
    step_t         st;
    frame_result_t none;
    logic [1:0]    fg_plan [4];
    logic [1:0]    bg_plan [4];
    int            fill_at;
    int            pick, sub, r, cc;
    none.data = '0;
    none.ibuf = 1'b0;
    fg_plan = '{2'd0, 2'd3, 2'd2, 2'd1};
    bg_plan = '{2'd3, 2'd0, 2'd1, 2'd2};
    n_err = 0;
    n_checked = 0;
    hold_req = 1'b0;
    burst_left = 1;
    aim_x = 0;
    aim_y = 0;
    rst_n                <= 1'b0;
    cmd_if.valid         <= 1'b0;
    cmd_if.command       <= psf_pkg::CMD_DRAW;
    cmd_if.x_position    <= '0;
    cmd_if.y_position    <= '0;
    cmd_if.buffer_select <= 1'b0;
    cmd_if.read_row      <= '0;
    cmd_if.byte_column   <= '0;
    cfg_we               <= 1'b0;
    cfg_idx              <= psf_pkg::CFG_FG;
    cfg_data             <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed table, the clearing pass holds off the first transaction
    build_directed();
    foreach (directed_q[i]) begin
      st = directed_q[i];
      if (st.is_cfg) begin
        settle();
        write_cfg(st.reg_idx, st.reg_val);
      end else begin
        send_cmd(st.cmd, st.typed, st.want);
        pace(1'b1);
      end
    end

    // random phases, each with its own colors, a long receiver hold-off at its start
    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_cfg(psf_pkg::CFG_FG, (p < 4) ? fg_plan[p] : 2'($urandom_range(0, 3)));
      write_cfg(psf_pkg::CFG_BG, (p < 4) ? bg_plan[p] : 2'($urandom_range(0, 3)));
      hold_req = 1'b1;
      fill_at = (p % 2 == 1) ? $urandom_range(20, PHASE_ITEMS - 1) : -1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // random content in every field, then shaped per command
        c.op  = psf_pkg::CMD_SWAP;
        c.x   = 9'($urandom_range(0, 511));
        c.y   = 9'($urandom_range(0, 511));
        c.sel = 1'($urandom_range(0, 1));
        c.row = 9'($urandom_range(0, 511));
        c.col = 7'($urandom_range(0, 127));
        pick  = $urandom_range(0, 99);
        sub   = $urandom_range(0, 99);
        if (k == fill_at) begin
          c.op = psf_pkg::CMD_FILL;
        end else if (pick < 46) begin
          c.op = psf_pkg::CMD_DRAW;
          if (sub < 80) begin
            c.x = 9'($urandom_range(0, SCR_W - 1));
            c.y = 9'($urandom_range(0, SCR_H - 1));
          end else if (sub < 93) begin
            // near the edges, mostly clipped on the right and bottom
            c.x = ($urandom_range(0, 1) == 1) ? 9'($urandom_range(SCR_W - 25, SCR_W - 1))
                                              : 9'($urandom_range(0, 3));
            c.y = ($urandom_range(0, 1) == 1) ? 9'($urandom_range(SCR_H - 22, SCR_H - 1))
                                              : 9'($urandom_range(0, 3));
          end
          aim_x = int'(c.x);
          aim_y = int'(c.y);
        end else if (pick < 88) begin
          c.op = psf_pkg::CMD_READ;
          if (sub < 60) begin
            // bytes in and around the last square
            r  = aim_y - 1 + $urandom_range(0, PT_SIZE + 1);
            cc = aim_x / 4 - 1 + $urandom_range(0, 6);
            if (r < 0) r = 0;
            if (cc < 0) cc = 0;
            c.row = r[8:0];
            c.col = cc[6:0];
            if ($urandom_range(0, 9) < 7) c.sel = draw_buf;
          end else if (sub < 88) begin
            c.row = 9'($urandom_range(0, SCR_H - 1));
            c.col = 7'($urandom_range(0, ROW_BYTES - 1));
          end
        end
        send_cmd(c, 1'b0, none);
        pace(k >= 16);
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d draws, %0d fills, %0d swaps, %0d reads (%0d nonzero), %0d color writes",
             n_draw, n_fill, n_swap, n_read, n_read_set, n_cfg);
    $display("%0d results compared in %0d cycles, %0d mismatches", n_checked, cycles, n_err);
    if (n_err == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/psf_pkg.sv
rtl/psf_if.sv
rtl/psf_front.sv
rtl/psf_queue.sv
rtl/psf_back.sv
rtl/packed_2bpp_square_fill_top.sv
tb/tb_packed_2bpp_square_fill_top.sv
